/* rtl/lmsw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_pkg
// shared types and constants for the scrolling led matrix frame sender
// ----------------------------------------------------------------------------
package lmsw_pkg;

    localparam int STORE_COLUMNS = 256;
    localparam int MAX_MATRICES  = 8;
    localparam int ROWS          = 8;

    localparam int DATA_W   = 8;
    localparam int ACTION_W = 2;
    localparam int OFF_W    = 10;
    localparam int CNT_W    = 4;
    localparam int ROW_W    = $clog2(ROWS);
    localparam int MAT_W    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int ADDR_W   = $clog2(STORE_COLUMNS);

    // signed column index: must hold the offset range and the store size
    localparam int COL_W_A  = OFF_W + 2;
    localparam int COL_W_B  = ADDR_W + 2;
    localparam int COL_W    = (COL_W_A > COL_W_B) ? COL_W_A : COL_W_B;

    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_OFFSET  = 2'd1,
        ACT_REFRESH = 2'd2,
        ACT_BCAST   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REFRESH,
        ST_BCAST
    } state_t;

endpackage

/* rtl/led_matrix_scroll_window_sender.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scroll_window_sender
// column store with scroll offset, emits register/data words to a chain of
// cascaded 8x8 led matrices
// ----------------------------------------------------------------------------
// sequence: a refresh sends 8*n words, a broadcast n words (n = live matrix
//   count), one word a cycle while out_stall is low; refresh reads use the
//   single column store read port; each word passes the read stage and the
//   output register; write and set-offset are taken only while idle
// reset: column valid bits cleared (store reads as zero), offset 0, count 1
// ----------------------------------------------------------------------------
module led_matrix_scroll_window_sender
(
    input  logic                              clk,
    input  logic                              rst_n,

    // config register: matrix count
    input  logic                              cfg_wr_en,
    input  logic [lmsw_pkg::CNT_W-1:0]        cfg_wr_data,

    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lmsw_pkg::ACTION_W-1:0]     action,
    input  logic [lmsw_pkg::DATA_W-1:0]       column_addr,
    input  logic [lmsw_pkg::DATA_W-1:0]       value,
    input  logic signed [lmsw_pkg::OFF_W-1:0] offset,
    input  logic [lmsw_pkg::DATA_W-1:0]       cmd_reg,
    input  logic [lmsw_pkg::DATA_W-1:0]       cmd_data,

    // output words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmsw_pkg::DATA_W-1:0]       reg_addr,
    output logic [lmsw_pkg::DATA_W-1:0]       pixel_data,
    output logic                              frame_end,
    output logic                              last
);

    // ------------------------------------------------------------------
    // state and storage
    // ------------------------------------------------------------------
    lmsw_pkg::state_t                     state_reg;
    lmsw_pkg::state_t                     state_next;

    logic [lmsw_pkg::CNT_W-1:0]           matrix_count_reg;
    logic signed [lmsw_pkg::OFF_W-1:0]    offset_reg;

    // column store: one write port (idle only), one registered read port
    logic [lmsw_pkg::DATA_W-1:0]          col_mem [lmsw_pkg::STORE_COLUMNS];
    // per-column written flag, cleared at reset so unwritten columns read zero
    logic [lmsw_pkg::STORE_COLUMNS-1:0]   col_valid_reg;

    // sequencer counters: matrix within row group, then row
    logic [lmsw_pkg::MAT_W-1:0]           mat_reg;
    logic [lmsw_pkg::ROW_W-1:0]           row_reg;
    logic [lmsw_pkg::DATA_W-1:0]          bc_reg_reg;
    logic [lmsw_pkg::DATA_W-1:0]          bc_data_reg;

    // read stage (data comes back from the store here)
    logic                                 s1_valid_reg;
    logic [lmsw_pkg::DATA_W-1:0]          s1_addr_reg;
    logic [lmsw_pkg::DATA_W-1:0]          s1_data_reg;
    logic                                 s1_use_mem_reg;
    logic                                 s1_fend_reg;
    logic                                 s1_last_reg;
    logic [lmsw_pkg::DATA_W-1:0]          rd_data_reg;
    logic                                 rd_hit_reg;

    // output register
    logic                                 out_valid_reg;
    logic [lmsw_pkg::DATA_W-1:0]          out_addr_reg;
    logic [lmsw_pkg::DATA_W-1:0]          out_data_reg;
    logic                                 out_fend_reg;
    logic                                 out_last_reg;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------
    lmsw_pkg::action_t                    act;
    logic                                 in_acc;
    logic                                 advance;
    logic                                 issue;
    logic [lmsw_pkg::CNT_W-1:0]           n_live;
    logic [lmsw_pkg::MAT_W-1:0]           n_m1;
    logic                                 last_m;
    logic                                 last_row;
    logic [lmsw_pkg::MAT_W-1:0]           idx;
    logic signed [lmsw_pkg::COL_W-1:0]    col;
    logic                                 col_in_range;
    logic [lmsw_pkg::ADDR_W-1:0]          rd_addr;
    logic signed [lmsw_pkg::COL_W-1:0]    new_off;
    logic signed [lmsw_pkg::COL_W-1:0]    off_low;
    logic                                 off_ok;
    logic                                 mem_we;
    logic [lmsw_pkg::ADDR_W-1:0]          wr_addr;

    assign act    = lmsw_pkg::action_t'(action);
    assign in_acc = in_valid && !in_stall;

    // the whole pipe moves when the output slot is free or being taken
    assign advance = !out_valid_reg || !out_stall;

    // clamp the register to 1..MAX_MATRICES
    always_comb
    begin
        if (matrix_count_reg == '0)
        begin
            n_live = lmsw_pkg::CNT_W'(1);
        end
        else if (32'(matrix_count_reg) > lmsw_pkg::MAX_MATRICES)
        begin
            n_live = lmsw_pkg::CNT_W'(lmsw_pkg::MAX_MATRICES);
        end
        else
        begin
            n_live = matrix_count_reg;
        end
    end

    assign n_m1     = lmsw_pkg::MAT_W'(n_live - lmsw_pkg::CNT_W'(1));
    assign last_m   = (mat_reg == n_m1);
    assign last_row = (row_reg == lmsw_pkg::ROW_LAST);

    // far matrix first: matrix index counts down from n-1
    assign idx = n_m1 - mat_reg;

    // column = offset + idx*8 + row
    assign col = lmsw_pkg::COL_W'(offset_reg)
               + $signed(lmsw_pkg::COL_W'({idx, 3'b000}))
               + $signed(lmsw_pkg::COL_W'(row_reg));

    assign col_in_range = !col[lmsw_pkg::COL_W-1]
                       && (col < lmsw_pkg::COL_W'(lmsw_pkg::STORE_COLUMNS));
    assign rd_addr = col[lmsw_pkg::ADDR_W-1:0];

    // set-offset window: -8*n .. STORE_COLUMNS
    assign new_off = lmsw_pkg::COL_W'(offset);
    assign off_low = -$signed(lmsw_pkg::COL_W'({n_live, 3'b000}));
    assign off_ok  = (new_off <= lmsw_pkg::COL_W'(lmsw_pkg::STORE_COLUMNS))
                  && (new_off >= off_low);

    // writes past the store are dropped
    assign mem_we  = in_acc && (act == lmsw_pkg::ACT_WRITE)
                  && (32'(column_addr) < lmsw_pkg::STORE_COLUMNS);
    assign wr_addr = lmsw_pkg::ADDR_W'(column_addr);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        issue      = 1'b0;
        unique case (state_reg)
            lmsw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (act)
                        lmsw_pkg::ACT_REFRESH: state_next = lmsw_pkg::ST_REFRESH;
                        lmsw_pkg::ACT_BCAST:   state_next = lmsw_pkg::ST_BCAST;
                        lmsw_pkg::ACT_WRITE,
                        lmsw_pkg::ACT_OFFSET:  state_next = lmsw_pkg::ST_IDLE;
                    endcase
                end
            end
            lmsw_pkg::ST_REFRESH:
            begin
                issue = advance;
                if (advance && last_m && last_row)
                begin
                    state_next = lmsw_pkg::ST_IDLE;
                end
            end
            lmsw_pkg::ST_BCAST:
            begin
                issue = advance;
                if (advance && last_m)
                begin
                    state_next = lmsw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lmsw_pkg::ST_IDLE;
            end
        endcase
    end

    // counters and latched broadcast word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            mat_reg <= '0;
            row_reg <= '0;
        end
        else if (issue)
        begin
            if (last_m)
            begin
                mat_reg <= '0;
                row_reg <= row_reg + lmsw_pkg::ROW_W'(1);
            end
            else
            begin
                mat_reg <= mat_reg + lmsw_pkg::MAT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && (act == lmsw_pkg::ACT_BCAST))
        begin
            bc_reg_reg  <= cmd_reg;
            bc_data_reg <= cmd_data;
        end
    end

    // ------------------------------------------------------------------
    // config register and scroll offset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_count_reg <= lmsw_pkg::CNT_W'(1);
            offset_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                matrix_count_reg <= cfg_wr_data;
            end
            if (in_acc && (act == lmsw_pkg::ACT_OFFSET) && off_ok)
            begin
                offset_reg <= offset;
            end
        end
    end

    // ------------------------------------------------------------------
    // column store
    // writes happen only while idle and read data is used only while sequencing,
    // so a used read never meets a write to the same column
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_valid_reg <= '0;
        end
        else if (mem_we)
        begin
            col_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            col_mem[wr_addr] <= value;
        end
        if (advance)
        begin
            rd_data_reg <= col_mem[rd_addr];
            rd_hit_reg  <= col_in_range && col_valid_reg[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // read stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (state_reg == lmsw_pkg::ST_REFRESH)
            begin
                s1_addr_reg    <= lmsw_pkg::DATA_W'(row_reg) + lmsw_pkg::DATA_W'(1);
                s1_use_mem_reg <= 1'b1;
                s1_last_reg    <= last_m && last_row;
            end
            else
            begin
                s1_addr_reg    <= bc_reg_reg;
                s1_use_mem_reg <= 1'b0;
                s1_last_reg    <= last_m;
            end
            s1_data_reg <= bc_data_reg;
            s1_fend_reg <= last_m;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_addr_reg <= s1_addr_reg;
            if (s1_use_mem_reg)
            begin
                // outside the store or never written: dark column
                out_data_reg <= rd_hit_reg ? rd_data_reg : '0;
            end
            else
            begin
                out_data_reg <= s1_data_reg;
            end
            out_fend_reg <= s1_fend_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_addr   = out_addr_reg;
    assign pixel_data = out_data_reg;
    assign frame_end  = out_fend_reg;
    assign last       = out_last_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
`ifndef SYNTH
    // the final word of any sequence always closes a row group
    a_last_has_fend : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> frame_end)
        else $error("last word without frame_end");

    // matrix counter never runs past the live count while sequencing
    a_mat_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lmsw_pkg::ST_IDLE) |-> (mat_reg <= n_m1))
        else $error("matrix counter beyond live count");

    // the final refresh word returns the sequencer to idle
    a_refresh_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lmsw_pkg::ST_REFRESH && issue && last_m && last_row)
        |=> (state_reg == lmsw_pkg::ST_IDLE))
        else $error("refresh did not end after last row");
`endif

endmodule
